### rtl/lpg_pkg.sv
// Shared types and constants for the LED pattern generator.
// Used by lpg_div.sv and led_pattern_generator.sv; no dependencies.
package lpg_pkg;

    // Shared serial divider: 32-bit dividend, divisor up to on+off flash length.
    localparam int DIV_W     = 32;
    localparam int DSR_W     = 17;
    localparam int DIV_STEPS = 32;
    localparam int CNT_W     = $clog2(DIV_STEPS + 1);

    // Wave entries are Q16 and reach 1.0 at mid-period.
    localparam int WAVE_W    = 17;
    localparam int WAVE_FRAC = 16;

    localparam logic [31:0] SOS_STEP_MS = 32'd150;
    localparam logic [7:0]  FULL_SCALE  = 8'd255;

    // SOS on/off sequence, bit i is step i (32 steps).
    localparam logic [31:0] SOS_PATTERN = 32'h0547_7715;

    localparam logic [7:0]  BRIGHTNESS_RST     = 8'd255;
    localparam logic [15:0] SLOW_HALF_RST      = 16'd500;
    localparam logic [15:0] FAST_HALF_RST      = 16'd100;
    localparam logic [15:0] MOTION_HALF_RST    = 16'd250;
    localparam logic [15:0] TRANSMIT_HALF_RST  = 16'd50;
    localparam logic [15:0] PULSE_PERIOD_RST   = 16'd2000;
    localparam logic [15:0] FLASH_LEN_RST      = 16'd50;

    typedef enum logic [2:0] {
        CMD_TICK        = 3'd0,
        CMD_SET_PATTERN = 3'd1,
        CMD_FLASH       = 3'd2,
        CMD_FORCE_ON    = 3'd3,
        CMD_FORCE_OFF   = 3'd4,
        CMD_TOGGLE      = 3'd5
    } cmd_t;

    typedef enum logic [2:0] {
        PAT_OFF      = 3'd0,
        PAT_ON       = 3'd1,
        PAT_SLOW     = 3'd2,
        PAT_FAST     = 3'd3,
        PAT_MOTION   = 3'd4,
        PAT_TRANSMIT = 3'd5,
        PAT_SOS      = 3'd6,
        PAT_PULSE    = 3'd7
    } pattern_t;

    typedef enum logic [2:0] {
        CFG_BRIGHTNESS    = 3'd0,
        CFG_ACTIVE_LOW    = 3'd1,
        CFG_SLOW_HALF     = 3'd2,
        CFG_FAST_HALF     = 3'd3,
        CFG_MOTION_HALF   = 3'd4,
        CFG_TRANSMIT_HALF = 3'd5,
        CFG_PULSE_PERIOD  = 3'd6
    } cfg_idx_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_TICK,
        ST_FLASH_DIV,
        ST_PULSE_DIV,
        ST_PULSE_SCALE,
        ST_PULSE_IDX,
        ST_WAVE_READ,
        ST_WAVE_MUL,
        ST_WAVE_DUTY,
        ST_EMIT
    } lpg_state_t;

    typedef struct packed {
        logic             start;
        logic             short_run;
        logic [DIV_W-1:0] dividend;
        logic [DSR_W-1:0] divisor;
    } lpg_div_ctl_t;

    typedef struct packed {
        logic             done;
        logic [DIV_W-1:0] quotient;
        logic [DSR_W-1:0] remainder;
    } lpg_div_sts_t;

endpackage

### rtl/lpg_div.sv
// Bit-serial restoring divider, one quotient bit per cycle.
// Depends on lpg_pkg. A short run takes SHORT_STEPS bits for a dividend
// known to be below divisor << SHORT_STEPS.
module lpg_div
    import lpg_pkg::*;
#(
    parameter int SHORT_STEPS = 6
)
(
    input  logic         clk,
    input  logic         rst_n,
    input  lpg_div_ctl_t ctl,
    output lpg_div_sts_t sts
);

    localparam logic [CNT_W-1:0] SHORT_CNT = CNT_W'(SHORT_STEPS);
    localparam logic [CNT_W-1:0] FULL_CNT  = CNT_W'(DIV_STEPS);

    logic             busy_reg;
    logic             done_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic [DSR_W-1:0] rem_reg;
    logic [DSR_W-1:0] rem_next;
    logic [DIV_W-1:0] dq_reg;
    logic [DIV_W-1:0] dq_next;
    logic [DSR_W-1:0] dsr_reg;
    logic [DSR_W+1:0] trial;
    logic             ge;

    // Trial subtract of the divisor from the shifted partial remainder.
    assign trial    = {1'b0, rem_reg, dq_reg[DIV_W-1]} - {2'b00, dsr_reg};
    assign ge       = ~trial[DSR_W+1];
    assign rem_next = ge ? trial[DSR_W-1:0] : {rem_reg[DSR_W-2:0], dq_reg[DIV_W-1]};
    assign dq_next  = {dq_reg[DIV_W-2:0], ge};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (ctl.start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= ctl.short_run ? SHORT_CNT : FULL_CNT;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == CNT_W'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.start)
        begin
            dsr_reg <= ctl.divisor;
            if (ctl.short_run)
            begin
                rem_reg <= DSR_W'(ctl.dividend >> SHORT_STEPS);
                dq_reg  <= ctl.dividend << (DIV_W - SHORT_STEPS);
            end
            else
            begin
                rem_reg <= '0;
                dq_reg  <= ctl.dividend;
            end
        end
        else if (busy_reg)
        begin
            rem_reg <= rem_next;
            dq_reg  <= dq_next;
        end
    end

    assign sts.done      = done_reg;
    assign sts.quotient  = dq_reg;
    assign sts.remainder = rem_reg;

endmodule

### rtl/led_pattern_generator.sv
// LED pattern generator: one word in, one result word out, one word at a time.
// Commands go from idle to the emit state; a plain tick passes the tick state
// first. A flash tick runs one divide and a pulse tick up to two, so both long
// cases are set by the bit-serial divider (one bit a cycle).
// The next word is taken when the previous one has reached the output register.
// Async active-low reset restores control and config registers; datapath and output word are not reset.
module led_pattern_generator
    import lpg_pkg::*;
#(
    parameter int WAVE_TABLE_DEPTH = 64
)
(
    input  logic        clk,
    input  logic        rst_n,
    // input channel
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [2:0]  command,
    input  logic [2:0]  pattern_sel,
    input  logic [15:0] flash_cycles,
    input  logic [15:0] flash_on_ms,
    input  logic [15:0] flash_off_ms,
    // output channel
    output logic        out_valid,
    input  logic        out_stall,
    output logic [7:0]  duty,
    output logic        lit,
    output logic        flash_active,
    output logic [2:0]  active_pattern,
    // configuration
    input  logic        cfg_we,
    input  logic [2:0]  cfg_index,
    input  logic [15:0] cfg_data
);

    // Index of the wave ROM; the second divide yields exactly these bits.
    localparam int IDX_W = $clog2(WAVE_TABLE_DEPTH);
    localparam logic [IDX_W:0] DEPTH_C = (IDX_W + 1)'(WAVE_TABLE_DEPTH);
    localparam longint unsigned DD = longint'(WAVE_TABLE_DEPTH) * longint'(WAVE_TABLE_DEPTH);

    // ------------------------------------------------------------------
    // Breathing wave ROM: (1-cos)/2 approximation, Q16, built at elaboration.
    // ------------------------------------------------------------------
    logic [WAVE_W-1:0] wave_rom [WAVE_TABLE_DEPTH];

    for (genvar gi = 0; gi < WAVE_TABLE_DEPTH; gi++)
    begin : g_wave
        localparam longint unsigned PI_C =
            longint'(gi) * (longint'(WAVE_TABLE_DEPTH) - longint'(gi));
        localparam longint unsigned SI_C = (64'd1048576 * PI_C) / (64'd5 * DD - 64'd4 * PI_C);
        localparam longint unsigned WI_C = (SI_C * SI_C) >> 16;
        assign wave_rom[gi] = WAVE_W'(WI_C);
    end

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic [7:0]  brightness_reg;
    logic        active_low_reg;
    logic [15:0] slow_half_reg;
    logic [15:0] fast_half_reg;
    logic [15:0] motion_half_reg;
    logic [15:0] transmit_half_reg;
    logic [15:0] pulse_period_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            brightness_reg    <= BRIGHTNESS_RST;
            active_low_reg    <= 1'b0;
            slow_half_reg     <= SLOW_HALF_RST;
            fast_half_reg     <= FAST_HALF_RST;
            motion_half_reg   <= MOTION_HALF_RST;
            transmit_half_reg <= TRANSMIT_HALF_RST;
            pulse_period_reg  <= PULSE_PERIOD_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_idx_t'(cfg_index))
                CFG_BRIGHTNESS:    brightness_reg    <= cfg_data[7:0];
                CFG_ACTIVE_LOW:    active_low_reg    <= cfg_data[0];
                CFG_SLOW_HALF:     slow_half_reg     <= cfg_data;
                CFG_FAST_HALF:     fast_half_reg     <= cfg_data;
                CFG_MOTION_HALF:   motion_half_reg   <= cfg_data;
                CFG_TRANSMIT_HALF: transmit_half_reg <= cfg_data;
                CFG_PULSE_PERIOD:  pulse_period_reg  <= cfg_data;
                default: ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Pattern state
    // ------------------------------------------------------------------
    lpg_state_t  state_reg,      state_next;
    logic [31:0] now_ms_reg,     now_ms_next;
    logic [31:0] last_step_reg,  last_step_next;
    logic [31:0] flash_start_reg, flash_start_next;
    logic        led_lit_reg,    led_lit_next;
    pattern_t    pattern_reg,    pattern_next;
    logic        in_flash_reg,   in_flash_next;
    logic [15:0] flash_target_reg, flash_target_next;
    logic [15:0] flash_on_reg,   flash_on_next;
    logic [15:0] flash_off_reg,  flash_off_next;
    logic [4:0]  sos_pos_reg,    sos_pos_next;
    logic [7:0]  duty_reg,       duty_next;
    logic        out_valid_reg,  out_valid_next;

    // Pulse datapath and output word (no reset needed)
    logic [DIV_W-1:0]       prod_reg,   prod_next;
    logic [IDX_W-1:0]       idx_reg,    idx_next;
    logic [WAVE_W-1:0]      wave_reg,   wave_next;
    logic [WAVE_W+7:0]      scaled_reg, scaled_next;
    logic [7:0]             out_duty_reg,    out_duty_next;
    logic                   out_lit_reg,     out_lit_next;
    logic                   out_flash_reg,   out_flash_next;
    logic [2:0]             out_pattern_reg, out_pattern_next;

    // Shared divider
    lpg_div_ctl_t div_ctl;
    lpg_div_sts_t div_sts;

    lpg_div #(
        .SHORT_STEPS (IDX_W)
    ) u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .ctl   (div_ctl),
        .sts   (div_sts)
    );

    // ------------------------------------------------------------------
    // Helpers
    // ------------------------------------------------------------------
    function automatic logic [7:0] polarity(input logic [7:0] v, input logic inv);
        return inv ? 8'(FULL_SCALE - v) : v;
    endfunction

    logic [15:0]       blink_half;
    logic [31:0]       since_step;
    logic              blink_due;
    logic              sos_due;
    logic [DSR_W-1:0]  flash_len;
    logic              flash_lit;
    logic              flash_over;
    logic [7:0]        on_duty;
    logic [7:0]        off_duty;
    logic [16+IDX_W:0] idx_scaled;
    pattern_t          sel_pat;

    always_comb
    begin
        case (pattern_reg)
            PAT_FAST:     blink_half = fast_half_reg;
            PAT_MOTION:   blink_half = motion_half_reg;
            PAT_TRANSMIT: blink_half = transmit_half_reg;
            default:      blink_half = slow_half_reg;
        endcase
    end

    // Elapsed times are modulo 2^32, like the millisecond counter.
    assign since_step = now_ms_reg - last_step_reg;
    assign blink_due  = since_step >= {16'd0, blink_half};
    assign sos_due    = since_step >= SOS_STEP_MS;

    assign flash_len  = {1'b0, flash_on_reg} + {1'b0, flash_off_reg};
    assign flash_lit  = div_sts.remainder < {1'b0, flash_on_reg};
    assign flash_over = div_sts.quotient >= {16'd0, flash_target_reg};

    assign on_duty    = polarity(brightness_reg, active_low_reg);
    assign off_duty   = polarity(8'd0, active_low_reg);

    // remainder of now / period is below 2^16
    assign idx_scaled = div_sts.remainder[15:0] * DEPTH_C;
    assign sel_pat    = pattern_t'(pattern_sel);

    assign in_stall   = (state_reg != ST_IDLE);

    // ------------------------------------------------------------------
    // Sequencer: next state and register updates
    // ------------------------------------------------------------------
    always_comb
    begin
        state_next        = state_reg;
        now_ms_next       = now_ms_reg;
        last_step_next    = last_step_reg;
        flash_start_next  = flash_start_reg;
        led_lit_next      = led_lit_reg;
        pattern_next      = pattern_reg;
        in_flash_next     = in_flash_reg;
        flash_target_next = flash_target_reg;
        flash_on_next     = flash_on_reg;
        flash_off_next    = flash_off_reg;
        sos_pos_next      = sos_pos_reg;
        duty_next         = duty_reg;
        prod_next         = prod_reg;
        idx_next          = idx_reg;
        wave_next         = wave_reg;
        scaled_next       = scaled_reg;
        out_duty_next     = out_duty_reg;
        out_lit_next      = out_lit_reg;
        out_flash_next    = out_flash_reg;
        out_pattern_next  = out_pattern_reg;

        div_ctl.start     = 1'b0;
        div_ctl.short_run = 1'b0;
        div_ctl.dividend  = now_ms_reg;
        div_ctl.divisor   = {1'b0, pulse_period_reg};

        // result word leaves when taken
        out_valid_next = out_valid_reg && out_stall;

        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = ST_EMIT;
                    case (cmd_t'(command))
                        CMD_TICK:
                        begin
                            now_ms_next = now_ms_reg + 32'd1;
                            state_next  = ST_TICK;
                        end
                        CMD_SET_PATTERN:
                        begin
                            if (sel_pat != pattern_reg)
                            begin
                                pattern_next   = sel_pat;
                                last_step_next = now_ms_reg;
                                led_lit_next   = 1'b0;
                                in_flash_next  = 1'b0;
                            end
                        end
                        CMD_FLASH:
                        begin
                            in_flash_next     = 1'b1;
                            flash_target_next = flash_cycles;
                            flash_on_next     = flash_on_ms;
                            flash_off_next    = flash_off_ms;
                            flash_start_next  = now_ms_reg;
                        end
                        CMD_FORCE_ON:
                        begin
                            led_lit_next = 1'b1;
                            duty_next    = on_duty;
                        end
                        CMD_FORCE_OFF:
                        begin
                            led_lit_next = 1'b0;
                            duty_next    = off_duty;
                        end
                        CMD_TOGGLE:
                        begin
                            led_lit_next = ~led_lit_reg;
                            duty_next    = led_lit_reg ? off_duty : on_duty;
                        end
                        default: ;
                    endcase
                end
            end

            ST_TICK:
            begin
                state_next = ST_EMIT;
                if (in_flash_reg)
                begin
                    if (flash_len == '0)
                    begin
                        // zero-length flash cycle: dark and done at once
                        led_lit_next  = 1'b0;
                        duty_next     = off_duty;
                        in_flash_next = 1'b0;
                        if (pattern_reg != PAT_OFF)
                        begin
                            pattern_next   = PAT_OFF;
                            last_step_next = now_ms_reg;
                        end
                    end
                    else
                    begin
                        div_ctl.start    = 1'b1;
                        div_ctl.dividend = now_ms_reg - flash_start_reg;
                        div_ctl.divisor  = flash_len;
                        state_next       = ST_FLASH_DIV;
                    end
                end
                else
                begin
                    case (pattern_reg)
                        PAT_OFF:
                        begin
                            led_lit_next = 1'b0;
                            duty_next    = off_duty;
                        end
                        PAT_ON:
                        begin
                            led_lit_next = 1'b1;
                            duty_next    = on_duty;
                        end
                        PAT_SLOW, PAT_FAST, PAT_MOTION, PAT_TRANSMIT:
                        begin
                            if (blink_due)
                            begin
                                led_lit_next   = ~led_lit_reg;
                                duty_next      = led_lit_reg ? off_duty : on_duty;
                                last_step_next = now_ms_reg;
                            end
                        end
                        PAT_SOS:
                        begin
                            if (sos_due)
                            begin
                                led_lit_next   = SOS_PATTERN[sos_pos_reg];
                                duty_next      = SOS_PATTERN[sos_pos_reg] ? on_duty : off_duty;
                                sos_pos_next   = sos_pos_reg + 5'd1;
                                last_step_next = now_ms_reg;
                            end
                        end
                        default:
                        begin
                            // breathing pulse: phase = now mod period
                            if (pulse_period_reg == '0)
                            begin
                                idx_next   = '0;
                                state_next = ST_WAVE_READ;
                            end
                            else
                            begin
                                div_ctl.start = 1'b1;
                                state_next    = ST_PULSE_DIV;
                            end
                        end
                    endcase
                end
            end

            ST_FLASH_DIV:
            begin
                if (div_sts.done)
                begin
                    led_lit_next = flash_lit;
                    duty_next    = flash_lit ? on_duty : off_duty;
                    if (flash_over)
                    begin
                        in_flash_next = 1'b0;
                        if (pattern_reg != PAT_OFF)
                        begin
                            pattern_next   = PAT_OFF;
                            last_step_next = now_ms_reg;
                            led_lit_next   = 1'b0;
                        end
                    end
                    state_next = ST_EMIT;
                end
            end

            ST_PULSE_DIV:
            begin
                if (div_sts.done)
                begin
                    prod_next  = DIV_W'(idx_scaled);
                    state_next = ST_PULSE_SCALE;
                end
            end

            ST_PULSE_SCALE:
            begin
                // index = phase * depth / period, quotient fits in IDX_W bits
                div_ctl.start     = 1'b1;
                div_ctl.short_run = 1'b1;
                div_ctl.dividend  = prod_reg;
                state_next        = ST_PULSE_IDX;
            end

            ST_PULSE_IDX:
            begin
                if (div_sts.done)
                begin
                    idx_next   = div_sts.quotient[IDX_W-1:0];
                    state_next = ST_WAVE_READ;
                end
            end

            ST_WAVE_READ:
            begin
                wave_next  = wave_rom[idx_reg];
                state_next = ST_WAVE_MUL;
            end

            ST_WAVE_MUL:
            begin
                scaled_next = wave_reg * brightness_reg;
                state_next  = ST_WAVE_DUTY;
            end

            ST_WAVE_DUTY:
            begin
                // pulse moves duty only, lit stays as it was
                duty_next  = polarity(scaled_reg[WAVE_FRAC +: 8], active_low_reg);
                state_next = ST_EMIT;
            end

            ST_EMIT:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    out_valid_next   = 1'b1;
                    out_duty_next    = duty_reg;
                    out_lit_next     = led_lit_reg;
                    out_flash_next   = in_flash_reg;
                    out_pattern_next = pattern_reg;
                    state_next       = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // ------------------------------------------------------------------
    // Registers
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_IDLE;
            now_ms_reg       <= '0;
            last_step_reg    <= '0;
            flash_start_reg  <= '0;
            led_lit_reg      <= 1'b0;
            pattern_reg      <= PAT_OFF;
            in_flash_reg     <= 1'b0;
            flash_target_reg <= '0;
            flash_on_reg     <= FLASH_LEN_RST;
            flash_off_reg    <= FLASH_LEN_RST;
            sos_pos_reg      <= '0;
            duty_reg         <= '0;    // off level, active_low resets to 0
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            now_ms_reg       <= now_ms_next;
            last_step_reg    <= last_step_next;
            flash_start_reg  <= flash_start_next;
            led_lit_reg      <= led_lit_next;
            pattern_reg      <= pattern_next;
            in_flash_reg     <= in_flash_next;
            flash_target_reg <= flash_target_next;
            flash_on_reg     <= flash_on_next;
            flash_off_reg    <= flash_off_next;
            sos_pos_reg      <= sos_pos_next;
            duty_reg         <= duty_next;
            out_valid_reg    <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        prod_reg        <= prod_next;
        idx_reg         <= idx_next;
        wave_reg        <= wave_next;
        scaled_reg      <= scaled_next;
        out_duty_reg    <= out_duty_next;
        out_lit_reg     <= out_lit_next;
        out_flash_reg   <= out_flash_next;
        out_pattern_reg <= out_pattern_next;
    end

    assign out_valid      = out_valid_reg;
    assign duty           = out_duty_reg;
    assign lit            = out_lit_reg;
    assign flash_active   = out_flash_reg;
    assign active_pattern = out_pattern_reg;

endmodule

### tb/testbench.sv
// Self-checking testbench for led_pattern_generator: directed table, then random phases.
// Depends on lpg_pkg (command, pattern and register codes) and the RTL of the block.
`timescale 1ns / 1ps

module testbench;
    import lpg_pkg::*;

    // ---------------------------------------------------------------------
    // Local constants and types
    // ---------------------------------------------------------------------
    localparam int WAVE_DEPTH    = 64;
    localparam int N_DIRECTED    = 24;
    localparam int SHOW_MAX      = 10;
    localparam int SETTLE_CYCLES = 64;         // longer than the slowest pulse tick
    localparam int LONG_HOLD     = 300;        // receiver hold-off, in cycles
    localparam longint RUN_LIMIT_NS = 4_000_000;

    localparam logic [2:0]  CMD_SPARE_A = 3'd6;  // unused codes, block must ignore
    localparam logic [2:0]  CMD_SPARE_B = 3'd7;
    localparam logic [7:0]  FULL_LEVEL  = 8'd255;
    localparam logic [31:0] SOS_STEP    = 32'd150;
    // Morse S-O-S on/off steps, step 0 is the leftmost bit
    localparam bit [0:31]   MORSE_SOS   = 32'b1010_1000_1110_1110_1110_0010_1010_0000;

    typedef enum int {
        IDLE_NONE,
        IDLE_SENDER,
        IDLE_RECEIVER,
        IDLE_BOTH
    } idle_mode_t;

    typedef struct packed {
        logic [2:0]  cmd;
        logic [2:0]  pat;
        logic [15:0] cycles;
        logic [15:0] on_ms;
        logic [15:0] off_ms;
    } led_word_t;

    typedef struct packed {
        logic [7:0] duty;
        logic       lit;
        logic       flash;
        logic [2:0] pattern;
    } led_view_t;

    typedef struct packed {
        logic [7:0]  bright;
        logic        act_low;
        logic [15:0] slow;
        logic [15:0] fast;
        logic [15:0] motion;
        logic [15:0] transmit;
        logic [15:0] period;
    } led_cfg_t;

    // Directed row: the word, and a hand-typed result where it is obvious.
    typedef struct packed {
        led_word_t word;
        logic      typed;
        led_view_t view;
    } dir_row_t;

    // ---------------------------------------------------------------------
    // DUT signals; every input known from time zero
    // ---------------------------------------------------------------------
    logic        clk          = 1'b0;
    logic        rst_n        = 1'b0;
    logic        in_valid     = 1'b0;
    logic        in_stall;
    logic [2:0]  command      = CMD_TICK;
    logic [2:0]  pattern_sel  = PAT_OFF;
    logic [15:0] flash_cycles = '0;
    logic [15:0] flash_on_ms  = '0;
    logic [15:0] flash_off_ms = '0;
    logic        out_valid;
    logic        out_stall    = 1'b0;
    logic [7:0]  duty;
    logic        lit;
    logic        flash_active;
    logic [2:0]  active_pattern;
    logic        cfg_we       = 1'b0;
    logic [2:0]  cfg_index    = CFG_BRIGHTNESS;
    logic [15:0] cfg_data     = '0;

    led_pattern_generator #(
        .WAVE_TABLE_DEPTH (WAVE_DEPTH)
    ) u_dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .command        (command),
        .pattern_sel    (pattern_sel),
        .flash_cycles   (flash_cycles),
        .flash_on_ms    (flash_on_ms),
        .flash_off_ms   (flash_off_ms),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .duty           (duty),
        .lit            (lit),
        .flash_active   (flash_active),
        .active_pattern (active_pattern),
        .cfg_we         (cfg_we),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data)
    );

    // ---------------------------------------------------------------------
    // LED behavior model: config copy and state, all at power-on values
    // ---------------------------------------------------------------------
    logic [7:0]  cfg_bright   = 8'd255;
    logic        cfg_act_low  = 1'b0;
    logic [15:0] cfg_slow     = 16'd500;
    logic [15:0] cfg_fast     = 16'd100;
    logic [15:0] cfg_motion   = 16'd250;
    logic [15:0] cfg_transmit = 16'd50;
    logic [15:0] cfg_period   = 16'd2000;

    logic [31:0] now_ms        = '0;
    logic [31:0] last_step     = '0;
    logic [31:0] flash_start   = '0;
    logic        led_on        = 1'b0;
    pattern_t    cur_pat       = PAT_OFF;
    logic        flashing      = 1'b0;
    logic [15:0] flash_goal    = '0;
    logic [15:0] flash_on_len  = 16'd50;
    logic [15:0] flash_off_len = 16'd50;
    logic [4:0]  sos_pos       = '0;
    logic [7:0]  duty_q        = 8'd0;

    led_view_t pending_views[$];    // results still owed by the block
    int        mismatches     = 0;
    int        send_idle_pct  = 0;
    int        recv_stall_pct = 0;
    int        hold_req       = 0;  // bumped by the sequencer to start a long hold-off

    // Duty value as written to the pin, honoring polarity.
    function automatic logic [7:0] polar(input logic [7:0] v);
        return cfg_act_low ? FULL_LEVEL - v : v;
    endfunction

    function automatic void drive_led(input logic on);
        led_on = on;
        duty_q = polar(on ? cfg_bright : 8'd0);
    endfunction

    // A new pattern restarts its timer, clears lit and cancels any flash;
    // the duty already written stays until a later tick or LED command.
    function automatic void pick_pattern(input pattern_t p);
        if (p != cur_pat)
        begin
            cur_pat   = p;
            last_step = now_ms;
            led_on    = 1'b0;
            flashing  = 1'b0;
        end
    endfunction

    function automatic void blink_led(input logic [15:0] half);
        if ((now_ms - last_step) >= 32'(half))
        begin
            drive_led(!led_on);
            last_step = now_ms;
        end
    endfunction

    // Q16 (1-cos)/2 breathing curve, rational approximation.
    function automatic longint unsigned breath_level(input longint unsigned i);
        longint unsigned d;
        longint unsigned p;
        longint unsigned s;
        d = WAVE_DEPTH;
        p = i * (d - i);
        s = (64'd16 * p * 64'd65536) / (64'd5 * d * d - 64'd4 * p);
        return (s * s) >> 16;
    endfunction

    function automatic void tick_led();
        logic [31:0] elapsed;
        logic [31:0] span;
        longint unsigned idx;
        longint unsigned scaled;
        now_ms = now_ms + 32'd1;
        if (flashing)
        begin
            // flash overrides the pattern; zero cycle length ends it at once
            elapsed = now_ms - flash_start;
            span    = 32'(flash_on_len) + 32'(flash_off_len);
            if (span == 32'd0)
            begin
                drive_led(1'b0);
                flashing = 1'b0;
                pick_pattern(PAT_OFF);
            end
            else
            begin
                drive_led((elapsed % span) < 32'(flash_on_len));
                if ((elapsed / span) >= 32'(flash_goal))
                begin
                    flashing = 1'b0;
                    pick_pattern(PAT_OFF);
                end
            end
        end
        else
        begin
            case (cur_pat)
                PAT_OFF:      drive_led(1'b0);
                PAT_ON:       drive_led(1'b1);
                PAT_SLOW:     blink_led(cfg_slow);
                PAT_FAST:     blink_led(cfg_fast);
                PAT_MOTION:   blink_led(cfg_motion);
                PAT_TRANSMIT: blink_led(cfg_transmit);
                PAT_SOS:
                begin
                    if ((now_ms - last_step) >= SOS_STEP)
                    begin
                        drive_led(MORSE_SOS[sos_pos]);
                        sos_pos   = sos_pos + 5'd1;
                        last_step = now_ms;
                    end
                end
                default:
                begin
                    // breathing: index by phase in period, scale by brightness
                    idx = 0;
                    if (cfg_period != 16'd0)
                        idx = (longint'(now_ms % 32'(cfg_period)) * WAVE_DEPTH)
                              / longint'(cfg_period);
                    scaled = (breath_level(idx) * longint'(cfg_bright)) >> 16;
                    duty_q = polar(scaled[7:0]);
                end
            endcase
        end
    endfunction

    // Applies one accepted word to the model and returns the result it owes.
    function automatic led_view_t advance_led(input led_word_t w);
        led_view_t v;
        case (w.cmd)
            CMD_TICK:        tick_led();
            CMD_SET_PATTERN: pick_pattern(pattern_t'(w.pat));
            CMD_FLASH:
            begin
                flashing      = 1'b1;
                flash_goal    = w.cycles;
                flash_on_len  = w.on_ms;
                flash_off_len = w.off_ms;
                flash_start   = now_ms;
            end
            CMD_FORCE_ON:    drive_led(1'b1);
            CMD_FORCE_OFF:   drive_led(1'b0);
            CMD_TOGGLE:      drive_led(!led_on);
            default:         ;
        endcase
        v.duty    = duty_q;
        v.lit     = led_on;
        v.flash   = flashing;
        v.pattern = cur_pat;
        return v;
    endfunction

    // ---------------------------------------------------------------------
    // Directed table: reset behavior, every command, unused codes, flash
    // extremes, zero-length flash, flash end, SOS, pulse, same-pattern set.
    // ---------------------------------------------------------------------
    dir_row_t directed_rows [N_DIRECTED] = '{
        '{'{CMD_TICK,        PAT_OFF,      16'h0000, 16'h0000, 16'h0000}, 1'b1,
          '{8'd0,   1'b0, 1'b0, PAT_OFF}},
        '{'{CMD_FORCE_ON,    PAT_ON,       16'hFFFF, 16'h0000, 16'hFFFF}, 1'b1,
          '{8'd255, 1'b1, 1'b0, PAT_OFF}},
        '{'{CMD_TOGGLE,      PAT_OFF,      16'h0000, 16'hFFFF, 16'h0000}, 1'b1,
          '{8'd0,   1'b0, 1'b0, PAT_OFF}},
        '{'{CMD_TOGGLE,      PAT_PULSE,    16'h0000, 16'h0000, 16'h0000}, 1'b1,
          '{8'd255, 1'b1, 1'b0, PAT_OFF}},
        '{'{CMD_FORCE_OFF,   PAT_OFF,      16'h0000, 16'h0000, 16'h0000}, 1'b1,
          '{8'd0,   1'b0, 1'b0, PAT_OFF}},
        '{'{CMD_SPARE_A,     PAT_PULSE,    16'hFFFF, 16'hFFFF, 16'hFFFF}, 1'b1,
          '{8'd0,   1'b0, 1'b0, PAT_OFF}},
        '{'{CMD_SPARE_B,     PAT_ON,       16'h0000, 16'h0000, 16'h0000}, 1'b1,
          '{8'd0,   1'b0, 1'b0, PAT_OFF}},
        '{'{CMD_SET_PATTERN, PAT_ON,       16'h0000, 16'h0000, 16'h0000}, 1'b0, '0},
        '{'{CMD_TICK,        PAT_OFF,      16'h0000, 16'h0000, 16'h0000}, 1'b0, '0},
        '{'{CMD_SET_PATTERN, PAT_FAST,     16'h0000, 16'h0000, 16'h0000}, 1'b0, '0},
        '{'{CMD_TICK,        PAT_OFF,      16'h0000, 16'h0000, 16'h0000}, 1'b0, '0},
        '{'{CMD_FLASH,       PAT_OFF,      16'hFFFF, 16'hFFFF, 16'hFFFF}, 1'b0, '0},
        '{'{CMD_TICK,        PAT_OFF,      16'h0000, 16'h0000, 16'h0000}, 1'b0, '0},
        '{'{CMD_FLASH,       PAT_OFF,      16'h0000, 16'h0000, 16'h0000}, 1'b0, '0},
        '{'{CMD_TICK,        PAT_OFF,      16'h0000, 16'h0000, 16'h0000}, 1'b0, '0},
        '{'{CMD_SET_PATTERN, PAT_SOS,      16'h0000, 16'h0000, 16'h0000}, 1'b0, '0},
        '{'{CMD_TICK,        PAT_OFF,      16'h0000, 16'h0000, 16'h0000}, 1'b0, '0},
        '{'{CMD_SET_PATTERN, PAT_PULSE,    16'h0000, 16'h0000, 16'h0000}, 1'b0, '0},
        '{'{CMD_TICK,        PAT_OFF,      16'h0000, 16'h0000, 16'h0000}, 1'b0, '0},
        '{'{CMD_SET_PATTERN, PAT_PULSE,    16'h0000, 16'h0000, 16'h0000}, 1'b0, '0},
        '{'{CMD_FLASH,       PAT_OFF,      16'h0001, 16'h0001, 16'h0001}, 1'b0, '0},
        '{'{CMD_TICK,        PAT_OFF,      16'h0000, 16'h0000, 16'h0000}, 1'b0, '0},
        '{'{CMD_TICK,        PAT_OFF,      16'h0000, 16'h0000, 16'h0000}, 1'b0, '0},
        '{'{CMD_TICK,        PAT_OFF,      16'h0000, 16'h0000, 16'h0000}, 1'b0, '0}
    };

    // ---------------------------------------------------------------------
    // Clock and run limit
    // ---------------------------------------------------------------------
    initial
    begin
        forever #2 clk = ~clk;
    end

    initial
    begin
        #(RUN_LIMIT_NS);
        $display("testbench failed");
        $finish;
    end

    // ---------------------------------------------------------------------
    // Receiver: random stall, or a long hold-off counted here in cycles
    // ---------------------------------------------------------------------
    int hold_seen = 0;
    int hold_left = 0;

    always @(negedge clk)
    begin
        if (hold_req != hold_seen)
        begin
            hold_seen <= hold_req;
            hold_left <= LONG_HOLD;
            out_stall <= 1'b1;
        end
        else if (hold_left != 0)
        begin
            hold_left <= hold_left - 1;
            out_stall <= 1'b1;
        end
        else
        begin
            out_stall <= ($urandom_range(99) < recv_stall_pct);
        end
    end

    // ---------------------------------------------------------------------
    // Result checker: every accepted word against the oldest expectation
    // ---------------------------------------------------------------------
    always @(posedge clk)
    begin : check_result
        led_view_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_views.size() == 0)
            begin
                mismatches++;
                if (mismatches <= SHOW_MAX)
                    $display("unexpected result word: duty %0d lit %0d flash %0d pattern %0d",
                             duty, lit, flash_active, active_pattern);
            end
            else
            begin
                want = pending_views.pop_front();
                if (duty !== want.duty || lit !== want.lit ||
                    flash_active !== want.flash || active_pattern !== want.pattern)
                begin
                    mismatches++;
                    if (mismatches <= SHOW_MAX)
                        $display({"mismatch at %0t: duty %0d/%0d lit %0d/%0d ",
                                  "flash %0d/%0d pattern %0d/%0d (expected/actual)"},
                                 $realtime, want.duty, duty, want.lit, lit,
                                 want.flash, flash_active, want.pattern, active_pattern);
                end
            end
        end
    end

    // ---------------------------------------------------------------------
    // Sender side
    // ---------------------------------------------------------------------

    // Offers one word from a falling edge, waits for the handshake, queues the
    // expected result (hand-typed one if given), and returns on a falling edge.
    task automatic offer_word(input led_word_t w, input logic typed, input led_view_t typed_view);
        led_view_t v;
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid     <= 1'b1;
        command      <= w.cmd;
        pattern_sel  <= w.pat;
        flash_cycles <= w.cycles;
        flash_on_ms  <= w.on_ms;
        flash_off_ms <= w.off_ms;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        v = advance_led(w);
        pending_views.push_back(typed ? typed_view : v);
        @(negedge clk);
    endtask

    // Sender quiet until every result is in, then margin for the block to settle.
    task automatic wait_idle();
        in_valid <= 1'b0;
        while (pending_views.size() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    // Writes all seven registers, one per cycle; block must be idle.
    task automatic apply_settings(input led_cfg_t c);
        logic [15:0] vals [0:6];
        vals[CFG_BRIGHTNESS]    = {8'd0, c.bright};
        vals[CFG_ACTIVE_LOW]    = {15'd0, c.act_low};
        vals[CFG_SLOW_HALF]     = c.slow;
        vals[CFG_FAST_HALF]     = c.fast;
        vals[CFG_MOTION_HALF]   = c.motion;
        vals[CFG_TRANSMIT_HALF] = c.transmit;
        vals[CFG_PULSE_PERIOD]  = c.period;
        for (int i = CFG_BRIGHTNESS; i <= CFG_PULSE_PERIOD; i++)
        begin
            cfg_we    <= 1'b1;
            cfg_index <= 3'(i);
            cfg_data  <= vals[i];
            @(negedge clk);
        end
        cfg_we       <= 1'b0;
        cfg_bright   = c.bright;
        cfg_act_low  = c.act_low;
        cfg_slow     = c.slow;
        cfg_fast     = c.fast;
        cfg_motion   = c.motion;
        cfg_transmit = c.transmit;
        cfg_period   = c.period;
        @(negedge clk);
    endtask

    // Mostly short blink intervals so that toggles happen often; now and then
    // a zero or a full-range value.
    function automatic logic [15:0] random_half();
        case ($urandom_range(9))
            0:       return 16'd0;
            1:       return 16'($urandom);
            default: return 16'($urandom_range(1, 25));
        endcase
    endfunction

    function automatic led_cfg_t random_settings();
        led_cfg_t c;
        c.bright   = 8'($urandom_range(255));
        c.act_low  = 1'($urandom_range(1));
        c.slow     = random_half();
        c.fast     = random_half();
        c.motion   = random_half();
        c.transmit = random_half();
        case ($urandom_range(9))
            0:       c.period = 16'd0;
            1:       c.period = 16'($urandom);
            default: c.period = 16'($urandom_range(1, 300));
        endcase
        return c;
    endfunction

    // Flash lengths: mostly a few ms so flashes end inside the run.
    function automatic logic [15:0] random_flash_len(input int short_max);
        if ($urandom_range(7) == 0)
            return 16'($urandom);
        return 16'($urandom_range(0, short_max));
    endfunction

    // One random phase. Ticks dominate so time moves; pattern selects lean to
    // the phase's favored pattern so that it runs long enough to show its shape.
    task automatic run_phase(input int n_items, input idle_mode_t mode, input pattern_t favor,
                             input int tick_pct, input logic flash_ok, input logic hold);
        led_word_t w;
        int        r;
        case (mode)
            IDLE_NONE:     begin send_idle_pct = 0;  recv_stall_pct = 0;  end
            IDLE_SENDER:   begin send_idle_pct = 47; recv_stall_pct = 0;  end
            IDLE_RECEIVER: begin send_idle_pct = 0;  recv_stall_pct = 47; end
            default:       begin send_idle_pct = 22; recv_stall_pct = 22; end
        endcase
        if (hold)
            hold_req = hold_req + 1;    // receiver blocks; sender keeps offering
        for (int n = 0; n < n_items; n++)
        begin
            // don't-care fields carry random bits too
            w.pat    = 3'($urandom_range(7));
            w.cycles = 16'($urandom);
            w.on_ms  = 16'($urandom);
            w.off_ms = 16'($urandom);
            if ($urandom_range(99) < tick_pct)
            begin
                w.cmd = CMD_TICK;
            end
            else
            begin
                r = $urandom_range(99);
                if (r < 30)
                begin
                    w.cmd = CMD_SET_PATTERN;
                    if ($urandom_range(9) < 7)
                        w.pat = favor;
                end
                else if (r < 48 && flash_ok)
                begin
                    w.cmd    = CMD_FLASH;
                    w.cycles = random_flash_len(4);
                    w.on_ms  = random_flash_len(8);
                    w.off_ms = random_flash_len(8);
                end
                else if (r < 62)
                    w.cmd = CMD_FORCE_ON;
                else if (r < 76)
                    w.cmd = CMD_FORCE_OFF;
                else if (r < 90)
                    w.cmd = CMD_TOGGLE;
                else
                    w.cmd = $urandom_range(1) ? CMD_SPARE_A : CMD_SPARE_B;
            end
            offer_word(w, 1'b0, '0);
        end
        wait_idle();
    endtask

    // ---------------------------------------------------------------------
    // Sequencer
    // ---------------------------------------------------------------------
    initial
    begin
        // single reset at the start, released on a falling edge
        repeat (12) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // directed part on power-on settings, no idling
        for (int i = 0; i < N_DIRECTED; i++)
            offer_word(directed_rows[i].word, directed_rows[i].typed, directed_rows[i].view);
        wait_idle();

        // low extremes: zero slow interval (toggle every tick), zero pulse period,
        // active-low output, full brightness
        apply_settings('{8'd255, 1'b1, 16'd0, 16'd1, 16'd2, 16'd3, 16'd0});
        run_phase(60, IDLE_NONE, PAT_SLOW, 60, 1'b1, 1'b0);

        // high extremes: dark LED, longest intervals and period
        apply_settings('{8'd0, 1'b0, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF});
        run_phase(50, IDLE_SENDER, PAT_PULSE, 60, 1'b1, 1'b0);

        apply_settings(random_settings());
        run_phase(60, IDLE_RECEIVER, PAT_FAST, 60, 1'b1, 1'b0);

        // long receiver hold-off so the block backs up into its input
        apply_settings(random_settings());
        run_phase(60, IDLE_BOTH, PAT_TRANSMIT, 60, 1'b1, 1'b1);

        // SOS steps every 150 ms: long tick-heavy run without flashes
        apply_settings(random_settings());
        run_phase(300, IDLE_BOTH, PAT_SOS, 92, 1'b0, 1'b0);

        apply_settings(random_settings());
        run_phase(60, IDLE_SENDER, PAT_PULSE, 60, 1'b1, 1'b0);

        apply_settings(random_settings());
        run_phase(60, IDLE_RECEIVER, PAT_MOTION, 60, 1'b1, 1'b0);

        apply_settings(random_settings());
        run_phase(60, IDLE_NONE, PAT_ON, 60, 1'b1, 1'b0);

        if (mismatches == 0 && pending_views.size() == 0)
            $display("testbench passed");
        else
            $display("testbench failed");
        $finish;
    end

endmodule

### files.f
rtl/lpg_pkg.sv
rtl/lpg_div.sv
rtl/led_pattern_generator.sv
tb/testbench.sv
